[rtl/core/assert_macros.svh]
// Assertion macros for the watchdog RTL, included by wsw_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define WSW_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define WSW_ASSERT_NEXT(label, cond, consequent, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (consequent)) \
      else $error(msg);
`else
`define WSW_ASSERT(label, prop, msg)
`define WSW_ASSERT_NEXT(label, cond, consequent, msg)
`endif

`endif

[rtl/core/wsw_pkg.sv]
// Types and constants of the windowed service watchdog
package wsw_pkg;

   localparam int TIME_W    = 32;
   localparam int CMD_W     = 3;
   localparam int BYTE_W    = 8;
   localparam int TIMEOUT_W = 12;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_SERVICE   = 3'd0,
      CMD_OPEN      = 3'd1,
      CMD_RELEASE   = 3'd2,
      CMD_WRITE     = 3'd3,
      CMD_KEEPALIVE = 3'd4,
      CMD_REBOOT    = 3'd5
   } command_type;

   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_TIMEOUT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_TIMEOUT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_ONLY   = 2'd2;

   localparam logic [TIMEOUT_W-1:0] SHORT_TIMEOUT_RESET = 12'd60;
   localparam logic [TIMEOUT_W-1:0] LONG_TIMEOUT_RESET  = 12'd300;

   localparam logic [BYTE_W-1:0] CHAR_DISABLE = 8'h56;
   localparam logic [BYTE_W-1:0] CHAR_LONG    = 8'h54;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [TIME_W-1:0] now_time;
      logic [BYTE_W-1:0] data_byte;
      logic              last_byte;
   } req_item_type;

   typedef struct packed {
      logic kick;
      logic pin_level;
      logic expired;
      logic status;
   } rsp_item_type;

   typedef struct packed {
      logic [TIMEOUT_W-1:0] short_timeout_seconds;
      logic [TIMEOUT_W-1:0] long_timeout_seconds;
      logic                 kernel_only;
   } cfg_type;

endpackage

[rtl/core/wsw_if.sv]
// Request and response channel interfaces of the watchdog
interface wsw_req_if;
   import wsw_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     command;
   logic [TIME_W-1:0]    now_time;
   logic [BYTE_W-1:0]    data_byte;
   logic                 last_byte;

   modport source (output valid, command, now_time, data_byte, last_byte, input ready);
   modport sink   (input valid, command, now_time, data_byte, last_byte, output ready);
endinterface

interface wsw_rsp_if;
   logic valid;
   logic ready;
   logic kick;
   logic pin_level;
   logic expired;
   logic status;

   modport source (output valid, kick, pin_level, expired, status, input ready);
   modport sink   (input valid, kick, pin_level, expired, status, output ready);
endinterface

[rtl/core/windowed_service_watchdog.sv]
// Top level of the windowed service watchdog
//
//   channel  direction  handshake          payload
//   req_chan in         valid/ready        command, now_time, data_byte, last_byte
//   rsp_chan out        valid/ready        kick, pin_level, expired, status
//   csr_*    in         write enable only  csr_index, csr_write_data
//
// One request per cycle while the response register can drain; a request is held in the
// request register and its result in the response register, which offers the response.
// The latency is set by the request register and the response register.
// Synchronous reset clears state and restores timeouts of 60 and 300 seconds.
// A stalled response holds; the request register still takes a request when the
// response register drains in the same cycle.
module windowed_service_watchdog #(
   parameter int TICKS_PER_SECOND = 100
) (
   input  logic                          clock,
   input  logic                          reset,
   wsw_req_if.sink                       req_chan,
   wsw_rsp_if.source                     rsp_chan,
   input  logic                          csr_write_en,
   input  logic [wsw_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [wsw_pkg::TIMEOUT_W-1:0] csr_write_data
);
   import wsw_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff, in_item_in;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff, out_item_in;

   logic         advance;
   logic         req_take;
   logic         kernel_clear;
   cfg_type      cfg;
   rsp_item_type result;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_item_in.command   = req_chan.command;
      in_item_in.now_time  = req_chan.now_time;
      in_item_in.data_byte = req_chan.data_byte;
      in_item_in.last_byte = req_chan.last_byte;
      in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);
      out_item_in  = advance ? result : out_item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= in_item_in;
      end
      out_item_ff <= out_item_in;
   end

   wsw_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .kernel_clear   (kernel_clear),
      .cfg            (cfg)
   );

   wsw_core #(
      .TICKS_PER_SECOND (TICKS_PER_SECOND)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .fire         (advance),
      .item         (in_item_ff),
      .cfg          (cfg),
      .result       (result),
      .kernel_clear (kernel_clear)
   );

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.kick      = out_item_ff.kick;
   assign rsp_chan.pin_level = out_item_ff.pin_level;
   assign rsp_chan.expired   = out_item_ff.expired;
   assign rsp_chan.status    = out_item_ff.status;

endmodule

[rtl/core/wsw_csr.sv]
// Configuration registers of the watchdog
module wsw_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [wsw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [wsw_pkg::TIMEOUT_W-1:0]     csr_write_data,
   input  logic                              kernel_clear,
   output wsw_pkg::cfg_type                  cfg
);
   import wsw_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_SHORT_TIMEOUT: cfg_in.short_timeout_seconds = csr_write_data;
            CSR_LONG_TIMEOUT:  cfg_in.long_timeout_seconds  = csr_write_data;
            CSR_KERNEL_ONLY:   cfg_in.kernel_only           = csr_write_data[0];
            default: ;
         endcase
      end
      if (kernel_clear) begin
         cfg_in.kernel_only = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_timeout_seconds <= SHORT_TIMEOUT_RESET;
         cfg_ff.long_timeout_seconds  <= LONG_TIMEOUT_RESET;
         cfg_ff.kernel_only           <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/core/wsw_core.sv]
// Watchdog state and per-request command logic
`include "assert_macros.svh"

module wsw_core #(
   parameter int TICKS_PER_SECOND = 100
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  wsw_pkg::req_item_type item,
   input  wsw_pkg::cfg_type      cfg,
   output wsw_pkg::rsp_item_type result,
   output logic                  kernel_clear
);
   import wsw_pkg::*;

   localparam int TPS_W  = $clog2(TICKS_PER_SECOND + 1);
   localparam int PROD_W = TIMEOUT_W + TPS_W;
   localparam logic [TPS_W-1:0] TPS = TPS_W'(TICKS_PER_SECOND);

   logic [TIME_W-1:0] window_start_ff, window_start_in;
   logic [TIME_W-1:0] window_end_ff, window_end_in;
   logic service_required_ff, service_required_in;
   logic use_long_timeout_ff, use_long_timeout_in;
   logic expiry_warned_ff, expiry_warned_in;
   logic device_open_ff, device_open_in;
   logic reboot_pending_ff, reboot_pending_in;
   logic kick_level_ff, kick_level_in;

   logic                 in_window;
   logic                 alive;
   logic                 do_refresh;
   logic [TIMEOUT_W-1:0] secs;
   logic [PROD_W-1:0]    ticks;

   always_comb begin
      if (window_end_ff < window_start_ff) begin
         in_window = (item.now_time < window_end_ff) || (item.now_time >= window_start_ff);
      end else begin
         in_window = (item.now_time >= window_start_ff) && (item.now_time < window_end_ff);
      end
      alive = cfg.kernel_only || !service_required_ff || in_window;
   end

   always_comb begin
      window_start_in     = window_start_ff;
      window_end_in       = window_end_ff;
      service_required_in = service_required_ff;
      use_long_timeout_in = use_long_timeout_ff;
      expiry_warned_in    = expiry_warned_ff;
      device_open_in      = device_open_ff;
      reboot_pending_in   = reboot_pending_ff;
      kick_level_in       = kick_level_ff;
      do_refresh          = 1'b0;
      kernel_clear        = 1'b0;
      result              = '0;

      unique case (item.command)
         CMD_SERVICE: begin
            if (alive) begin
               result.kick   = 1'b1;
               kick_level_in = ~kick_level_ff;
            end else if (!expiry_warned_ff) begin
               expiry_warned_in = 1'b1;
               result.expired   = 1'b1;
            end
         end
         CMD_OPEN: begin
            if (device_open_ff) begin
               result.status = 1'b1;
            end else begin
               device_open_in      = 1'b1;
               service_required_in = 1'b1;
               use_long_timeout_in = 1'b0;
               do_refresh          = 1'b1;
            end
         end
         CMD_RELEASE: begin
            device_open_in = 1'b0;
         end
         CMD_WRITE: begin
            case (item.data_byte)
               CHAR_DISABLE: service_required_in = 1'b0;
               CHAR_LONG:    use_long_timeout_in = 1'b1;
               default: ;
            endcase
            do_refresh = item.last_byte;
         end
         CMD_KEEPALIVE: begin
            do_refresh = 1'b1;
         end
         CMD_REBOOT: begin
            use_long_timeout_in = 1'b0;
            service_required_in = 1'b1;
            kernel_clear        = fire;
            do_refresh          = 1'b1;
            reboot_pending_in   = 1'b1;
         end
         default: ;
      endcase

      secs  = use_long_timeout_in ? cfg.long_timeout_seconds : cfg.short_timeout_seconds;
      ticks = PROD_W'(secs) * PROD_W'(TPS);
      if (do_refresh && !reboot_pending_ff) begin
         window_start_in  = item.now_time;
         window_end_in    = item.now_time + TIME_W'(ticks);
         expiry_warned_in = 1'b0;
      end
      result.pin_level = kick_level_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_start_ff     <= '0;
         window_end_ff       <= '0;
         service_required_ff <= 1'b0;
         use_long_timeout_ff <= 1'b0;
         expiry_warned_ff    <= 1'b0;
         device_open_ff      <= 1'b0;
         reboot_pending_ff   <= 1'b0;
         kick_level_ff       <= 1'b0;
      end else if (fire) begin
         window_start_ff     <= window_start_in;
         window_end_ff       <= window_end_in;
         service_required_ff <= service_required_in;
         use_long_timeout_ff <= use_long_timeout_in;
         expiry_warned_ff    <= expiry_warned_in;
         device_open_ff      <= device_open_in;
         reboot_pending_ff   <= reboot_pending_in;
         kick_level_ff       <= kick_level_in;
      end
   end

   `WSW_ASSERT_NEXT(kick_toggles_pin, fire && result.kick, kick_level_ff != $past(kick_level_ff), "kick without pin toggle")
   `WSW_ASSERT_NEXT(expired_sets_warned, fire && result.expired, expiry_warned_ff, "expiry not latched")
   `WSW_ASSERT_NEXT(reboot_sticky, reboot_pending_ff, reboot_pending_ff, "reboot pending cleared")
   `WSW_ASSERT_NEXT(frozen_window, reboot_pending_ff && fire, $stable(window_end_ff) && $stable(window_start_ff), "window moved after reboot notice")

endmodule

[sim/testbench.sv]
// Testbench for the windowed service watchdog: directed and random requests checked by a predictor
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import wsw_pkg::*;

   localparam int TICKS = 100;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int DRAIN_LIMIT = 4000;
   localparam int MAX_PRINTED = 20;
   localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;
   localparam logic [BYTE_W-1:0] CHAR_QUIET = 8'h51;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [TIMEOUT_W-1:0] csr_write_data;

   wsw_req_if req_bus ();
   wsw_rsp_if rsp_bus ();

   windowed_service_watchdog #(.TICKS_PER_SECOND(TICKS)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_bus),
      .rsp_chan       (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // watchdog state as predicted
   cfg_type           wd_cfg;
   logic [TIME_W-1:0] win_start;
   logic [TIME_W-1:0] win_end;
   logic              service_req;
   logic              long_mode;
   logic              warned;
   logic              is_open;
   logic              reboot_seen;
   logic              pin;

   req_item_type request_q[$];
   rsp_item_type predicted_rsp_q[$];

   int error_count;
   int accepted_count;
   int checked_count;
   int kick_count;
   int expiry_count;
   int refusal_count;
   int reboot_count;
   int setting_count;

   // sender and receiver pacing
   int          burst_left;
   int          gap_left;
   int          max_gap;
   bit          sender_paused;
   logic [15:0] ready_pattern;
   int          holdoff_requests;
   int          holdoff_served;
   int          holdoff_left;
   int          cycle_count;

   // stimulus generation
   logic [TIME_W-1:0] gen_anchor;
   logic              gen_long;
   bit                allow_reboot;
   int                gen_count;

   task automatic report_mismatch(string msg);
      if (error_count < MAX_PRINTED)
         $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic bit in_window(logic [TIME_W-1:0] t);
      if (win_end < win_start)
         return t < win_end || t >= win_start;
      return t >= win_start && t < win_end;
   endfunction

   function automatic void refresh_window(logic [TIME_W-1:0] t);
      logic [TIME_W-1:0] secs;
      if (reboot_seen)
         return;
      secs = long_mode ? TIME_W'(wd_cfg.long_timeout_seconds)
                       : TIME_W'(wd_cfg.short_timeout_seconds);
      win_start = t;
      win_end = t + secs * TICKS;
      warned = 1'b0;
   endfunction

   function automatic rsp_item_type predict_watchdog_response(req_item_type r);
      rsp_item_type o;
      o = '0;
      case (r.command)
         CMD_SERVICE: begin
            if (wd_cfg.kernel_only || !service_req || in_window(r.now_time)) begin
               o.kick = 1'b1;
               pin = ~pin;
               kick_count++;
            end else if (!warned) begin
               warned = 1'b1;
               o.expired = 1'b1;
               expiry_count++;
            end
         end
         CMD_OPEN: begin
            if (is_open) begin
               o.status = 1'b1;
               refusal_count++;
            end else begin
               is_open = 1'b1;
               service_req = 1'b1;
               long_mode = 1'b0;
               refresh_window(r.now_time);
            end
         end
         CMD_RELEASE: is_open = 1'b0;
         CMD_WRITE: begin
            if (r.data_byte == CHAR_DISABLE)
               service_req = 1'b0;
            else if (r.data_byte == CHAR_LONG)
               long_mode = 1'b1;
            if (r.last_byte)
               refresh_window(r.now_time);
         end
         CMD_KEEPALIVE: refresh_window(r.now_time);
         CMD_REBOOT: begin
            long_mode = 1'b0;
            service_req = 1'b1;
            wd_cfg.kernel_only = 1'b0;
            refresh_window(r.now_time);
            reboot_seen = 1'b1;
            reboot_count++;
         end
         default: ;
      endcase
      o.pin_level = pin;
      return o;
   endfunction

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // driver
   always @(posedge clock) begin
      req_item_type taken;
      req_item_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            taken.command = req_bus.command;
            taken.now_time = req_bus.now_time;
            taken.data_byte = req_bus.data_byte;
            taken.last_byte = req_bus.last_byte;
            predicted_rsp_q.push_back(predict_watchdog_response(taken));
            accepted_count++;
         end
         if (!(req_bus.valid && !req_bus.ready)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (request_q.size() > 0 && !sender_paused) begin
               nxt = request_q.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.command <= nxt.command;
               req_bus.now_time <= nxt.now_time;
               req_bus.data_byte <= nxt.data_byte;
               req_bus.last_byte <= nxt.last_byte;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_bit(string name, logic want, logic got);
      if (got !== want)
         report_mismatch($sformatf("response %0d %s: expected %0b, got %0b",
                                   checked_count, name, want, got));
   endtask

   // monitor and receiver
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (predicted_rsp_q.size() == 0) begin
            report_mismatch("response arrived with no request outstanding");
         end else begin
            want = predicted_rsp_q.pop_front();
            check_bit("kick", want.kick, rsp_bus.kick);
            check_bit("pin_level", want.pin_level, rsp_bus.pin_level);
            check_bit("expired", want.expired, rsp_bus.expired);
            check_bit("status", want.status, rsp_bus.status);
         end
         checked_count++;
      end
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_bus.ready <= 1'b0;
      end else if (holdoff_requests != holdoff_served) begin
         holdoff_served++;
         holdoff_left = HOLDOFF_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ready_pattern[cycle_count % 16];
      end
      cycle_count++;
   end

   task automatic push_req(logic [CMD_W-1:0] c, logic [TIME_W-1:0] t,
                           logic [BYTE_W-1:0] b = '0, logic l = 1'b0);
      req_item_type r;
      r.command = c;
      r.now_time = t;
      r.data_byte = b;
      r.last_byte = l;
      request_q.push_back(r);
      gen_count++;
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [TIMEOUT_W-1:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_SHORT_TIMEOUT: wd_cfg.short_timeout_seconds = value;
         CSR_LONG_TIMEOUT:  wd_cfg.long_timeout_seconds = value;
         CSR_KERNEL_ONLY:   wd_cfg.kernel_only = value[0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(logic [TIMEOUT_W-1:0] short_s, logic [TIMEOUT_W-1:0] long_s,
                                logic kernel);
      write_csr(CSR_SHORT_TIMEOUT, short_s);
      write_csr(CSR_LONG_TIMEOUT, long_s);
      write_csr(CSR_KERNEL_ONLY, TIMEOUT_W'(kernel));
      setting_count++;
      @(negedge clock);
   endtask

   function automatic logic [TIME_W-1:0] window_span();
      return (gen_long ? TIME_W'(wd_cfg.long_timeout_seconds)
                       : TIME_W'(wd_cfg.short_timeout_seconds)) * TICKS;
   endfunction

   function automatic logic [TIME_W-1:0] pick_check_time();
      logic [TIME_W-1:0] span;
      span = window_span();
      case ($urandom_range(0, 9))
         0: return gen_anchor;
         1: return gen_anchor + span - 1;
         2: return gen_anchor + span;
         3: return gen_anchor + span + 1;
         4: return gen_anchor - 1;
         5, 6: return gen_anchor + $urandom_range(0, span);
         7: return gen_anchor + span + $urandom_range(0, span);
         default: return $urandom();
      endcase
   endfunction

   task automatic add_noise();
      logic [CMD_W-1:0] c;
      c = CMD_W'($urandom_range(0, 7));
      if (c == CMD_REBOOT && !allow_reboot)
         c = CMD_KEEPALIVE;
      push_req(c, $urandom(), BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   task automatic add_write();
      int n;
      logic [BYTE_W-1:0] b;
      logic [TIME_W-1:0] t;
      logic l;
      n = $urandom_range(1, 4);
      t = gen_anchor + $urandom_range(0, window_span());
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 4))
            0: b = CHAR_DISABLE;
            1: b = CHAR_LONG;
            2: b = CHAR_QUIET;
            default: b = BYTE_W'($urandom_range(0, 255));
         endcase
         l = (i == n - 1) && ($urandom_range(0, 5) != 0);
         if (b == CHAR_LONG)
            gen_long = 1'b1;
         push_req(CMD_WRITE, t, b, l);
      end
      if (l)
         gen_anchor = t;
   endtask

   task automatic add_session();
      int steps;
      logic [TIME_W-1:0] t;
      gen_long = 1'b0;
      if ($urandom_range(0, 3) == 0)
         t = 32'hFFFF_FFFF - $urandom_range(0, 2 * window_span() + 16);
      else
         t = $urandom();
      push_req(CMD_OPEN, t);
      gen_anchor = t;
      steps = $urandom_range(3, 12);
      for (int i = 0; i < steps; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: push_req(CMD_SERVICE, pick_check_time(),
                                 BYTE_W'($urandom_range(0, 255)));
            4, 5: begin
               t = gen_anchor + $urandom_range(0, window_span());
               push_req(CMD_KEEPALIVE, t);
               gen_anchor = t;
            end
            6, 7: add_write();
            8: push_req(CMD_OPEN, pick_check_time());
            default: add_noise();
         endcase
      end
      if ($urandom_range(0, 3) != 0)
         push_req(CMD_RELEASE, gen_anchor);
   endtask

   task automatic drain();
      int waited;
      waited = 0;
      while ((request_q.size() > 0 || req_bus.valid || predicted_rsp_q.size() > 0)
             && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (6) @(negedge clock);
   endtask

   task automatic pick_idling();
      ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                  : 16'($urandom()) | 16'h1111;
      max_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
   endtask

   task automatic run_phase(int n, bit with_holdoff, bit with_pause);
      int start;
      start = gen_count;
      pick_idling();
      while (gen_count - start < n) begin
         if ($urandom_range(0, 6) == 0)
            add_noise();
         else
            add_session();
      end
      if (with_holdoff)
         holdoff_requests++;
      if (with_pause) begin
         while (request_q.size() > 40)
            @(negedge clock);
         sender_paused = 1'b1;
         while (predicted_rsp_q.size() > 0 || req_bus.valid)
            @(negedge clock);
         sender_paused = 1'b0;
      end
      drain();
   endtask

   initial begin
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_bus.valid = 1'b0;
      req_bus.command = '0;
      req_bus.now_time = '0;
      req_bus.data_byte = '0;
      req_bus.last_byte = 1'b0;
      rsp_bus.ready = 1'b0;
      wd_cfg.short_timeout_seconds = SHORT_TIMEOUT_RESET;
      wd_cfg.long_timeout_seconds = LONG_TIMEOUT_RESET;
      wd_cfg.kernel_only = 1'b0;
      win_start = '0;
      win_end = '0;
      service_req = 1'b0;
      long_mode = 1'b0;
      warned = 1'b0;
      is_open = 1'b0;
      reboot_seen = 1'b0;
      pin = 1'b0;
      ready_pattern = 16'hFFFF;
      max_gap = 0;
      sender_paused = 1'b0;
      allow_reboot = 1'b0;
      gen_anchor = '0;
      gen_long = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset timeouts: short window 6000 ticks, long 30000
      push_req(CMD_SERVICE, 32'd0);
      push_req(CMD_OPEN, 32'd1000);
      push_req(CMD_OPEN, 32'd1200);
      push_req(CMD_SERVICE, 32'd999);
      push_req(CMD_SERVICE, 32'd998);
      push_req(CMD_KEEPALIVE, 32'd1000);
      push_req(CMD_SERVICE, 32'd1000);
      push_req(CMD_SERVICE, 32'd6999);
      push_req(CMD_SERVICE, 32'd7000);
      push_req(CMD_WRITE, 32'd2000, CHAR_LONG, 1'b0);
      push_req(CMD_WRITE, 32'd2000, CHAR_QUIET, 1'b1);
      push_req(CMD_SERVICE, 32'd31999);
      push_req(CMD_SERVICE, 32'd32000);
      push_req(CMD_WRITE, 32'd40000, CHAR_DISABLE, 1'b1);
      push_req(CMD_SERVICE, 32'd0);
      push_req(CMD_RELEASE, 32'd0);
      push_req(CMD_OPEN, 32'hFFFF_FFF0);
      push_req(CMD_SERVICE, 32'd5);
      push_req(CMD_SERVICE, 32'h0000_175F);
      push_req(CMD_SERVICE, 32'h0000_1760);
      push_req(CMD_SERVICE, 32'hFFFF_FFEF);
      push_req(CMD_SPARE_6, 32'hFFFF_FFFF, 8'hFF, 1'b1);
      push_req(CMD_SPARE_7, 32'd0);
      push_req(CMD_WRITE, 32'hFFFF_FFFF, 8'hFF, 1'b1);
      push_req(CMD_SERVICE, 32'hFFFF_FFFF);
      push_req(CMD_RELEASE, 32'd0);
      drain();

      run_phase(100, 1'b0, 1'b0);
      apply_setting(12'd1, 12'd4095, 1'b0);
      run_phase(100, 1'b1, 1'b0);
      apply_setting(12'd0, 12'd1, 1'b0);
      run_phase(100, 1'b0, 1'b1);
      apply_setting(12'd3600, 12'd3600, 1'b1);
      run_phase(90, 1'b0, 1'b0);
      apply_setting(12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)), 1'b0);
      run_phase(100, 1'b0, 1'b0);
      apply_setting(12'd4095, 12'd0, 1'b0);
      run_phase(100, 1'b1, 1'b1);
      apply_setting(12'd2, 12'd5, 1'b0);
      run_phase(100, 1'b0, 1'b0);

      // reboot notices freeze the window, so they come last
      apply_setting(12'd2, 12'd5, 1'b1);
      push_req(CMD_RELEASE, 32'd100);
      push_req(CMD_OPEN, 32'd5000);
      push_req(CMD_SERVICE, 32'd5210);
      push_req(CMD_REBOOT, 32'd6000);
      push_req(CMD_SERVICE, 32'd6199);
      push_req(CMD_SERVICE, 32'd6200);
      push_req(CMD_KEEPALIVE, 32'd9000000);
      push_req(CMD_SERVICE, 32'd9000000);
      push_req(CMD_WRITE, 32'd9000001, CHAR_LONG, 1'b1);
      push_req(CMD_REBOOT, 32'd7);
      push_req(CMD_SERVICE, 32'd6000);
      push_req(CMD_WRITE, 32'd8, CHAR_DISABLE, 1'b1);
      push_req(CMD_SERVICE, 32'd1);
      allow_reboot = 1'b1;
      run_phase(60, 1'b0, 1'b0);

      if (predicted_rsp_q.size() > 0)
         report_mismatch($sformatf("%0d responses never arrived", predicted_rsp_q.size()));
      $display("covered %0d requests over %0d register settings: %0d kicks, %0d expirations,",
               accepted_count, setting_count + 1, kick_count, expiry_count);
      $display("%0d refused opens, %0d reboot notices; %0d responses checked, %0d mismatches",
               refusal_count, reboot_count, checked_count, error_count);
      if (error_count == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

   initial begin
      #5ms;
      $display("timeout after %0d requests, %0d responses", accepted_count, checked_count);
      $display("testbench: FAIL");
      $finish;
   end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/wsw_pkg.sv
rtl/core/wsw_if.sv
rtl/core/wsw_csr.sv
rtl/core/wsw_core.sv
rtl/core/windowed_service_watchdog.sv
sim/testbench.sv
